@@ rtl/sptc_pkg.sv @@
// Shared constants, codes and arithmetic helpers for the scan point transform.
`timescale 1ns / 1ps

package sptc_pkg;

  localparam int IDX_W   = 12;
  localparam int RNG_W   = 24;
  localparam int REG_W   = 24;
  localparam int OUT_W   = 25;
  localparam int RED_W   = 23;
  localparam int SC_W    = 32;
  localparam int SC_STAGES = 9;

  // Angles are in units of 2^-20 rad.
  localparam logic [22:0] TWO_PI     = 23'd6588397;
  localparam logic [20:0] HALF_PI    = 21'd1647099;
  localparam logic [19:0] QUARTER_PI = 20'd823550;

  // floor(2^36 / TWO_PI); estimates the turn count one low at most.
  localparam logic [13:0] ANG_RECIP = 14'((64'd1 << 36) / 64'd6588397);

  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // Exact floor division of a 30-bit value: (n * ceil(2^36 / d)) >> 36.
  localparam int DIV_SHIFT = 36;
  localparam logic [33:0] DIV6  = 34'(((64'd1 << DIV_SHIFT) + 64'd5)  / 64'd6);
  localparam logic [33:0] DIV12 = 34'(((64'd1 << DIV_SHIFT) + 64'd11) / 64'd12);
  localparam logic [33:0] DIV20 = 34'(((64'd1 << DIV_SHIFT) + 64'd19) / 64'd20);
  localparam logic [33:0] DIV30 = 34'(((64'd1 << DIV_SHIFT) + 64'd29) / 64'd30);
  localparam logic [33:0] DIV42 = 34'(((64'd1 << DIV_SHIFT) + 64'd41) / 64'd42);
  localparam logic [33:0] DIV56 = 34'(((64'd1 << DIV_SHIFT) + 64'd55) / 64'd56);

  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_SRC_X       = 3'd2,
    REG_SRC_Y       = 3'd3,
    REG_SRC_HEADING = 3'd4,
    REG_TGT_X       = 3'd5,
    REG_TGT_Y       = 3'd6,
    REG_TGT_HEADING = 3'd7
  } reg_idx_t;

  // Round v / 2^30 half away from zero.
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [29:0] div_q(input logic [29:0] n, input logic [33:0] m);
    logic [63:0] p;
    p = 64'(n) * 64'(m);
    return 30'(p >> DIV_SHIFT);
  endfunction

  // Bring a 24-bit signed angle into [0, TWO_PI).
  function automatic logic [RED_W-1:0] reduce_ang(input logic signed [REG_W-1:0] v);
    logic signed [24:0] w;
    logic signed [24:0] tp;
    logic signed [24:0] t;
    w = 25'(v);
    tp = $signed({2'b00, TWO_PI});
    if (w < 0) begin
      t = w + tp;
      if (t < 0) begin
        t = t + tp;
      end
    end else if (w >= tp) begin
      t = w - tp;
    end else begin
      t = w;
    end
    return t[RED_W-1:0];
  endfunction

endpackage

@@ rtl/sptc_sincos.sv @@
// Pipelined Q30 sine and cosine of a reduced angle, nine register stages.
`timescale 1ns / 1ps

module sptc_sincos import sptc_pkg::*; (
  input  logic                   clk,
  input  logic [SC_STAGES-1:0]   en,
  input  logic [RED_W-1:0]       ang,
  output logic signed [SC_W-1:0] sn,
  output logic signed [SC_W-1:0] cs
);

  localparam logic [22:0] TH1 = 23'(HALF_PI) - 23'(QUARTER_PI);
  localparam logic [22:0] TH2 = 23'(2 * HALF_PI) - 23'(QUARTER_PI);
  localparam logic [22:0] TH3 = 23'(3 * HALF_PI) - 23'(QUARTER_PI);
  localparam logic [22:0] TH4 = 23'(4 * HALF_PI) - 23'(QUARTER_PI);

  logic [1:0]         quad [0:7];
  logic signed [30:0] x_p  [0:6];
  logic [29:0]        x2_p [1:6];
  logic [30:0]        sa2, ca2, sa4, ca4, sa6, ca6;
  logic [29:0]        sb3, cb3, sb5, cb5, cb7;
  logic signed [30:0] ts7;

  logic [2:0]         q_c;
  logic [23:0]        qh_c;
  logic signed [23:0] xr_c;
  logic [30:0]        tc_c;
  logic signed [SC_W-1:0] ts_s, tc_s;

  // Quadrant and residue in [-pi/4, pi/4].
  always_comb begin
    q_c = 3'(ang >= TH1) + 3'(ang >= TH2) + 3'(ang >= TH3) + 3'(ang >= TH4);
    case (q_c)
      3'd1:    qh_c = 24'(HALF_PI);
      3'd2:    qh_c = 24'(2 * HALF_PI);
      3'd3:    qh_c = 24'(3 * HALF_PI);
      3'd4:    qh_c = 24'(4 * HALF_PI);
      default: qh_c = 24'd0;
    endcase
    xr_c = $signed(24'(ang) - qh_c);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad[0] <= q_c[1:0];
      x_p[0]  <= $signed({xr_c[20:0], 10'b0});
    end
    if (en[1]) begin
      quad[1] <= quad[0];
      x_p[1]  <= x_p[0];
      x2_p[1] <= 30'(rnd30(64'(x_p[0]) * 64'(x_p[0])));
    end
    if (en[2]) begin
      quad[2] <= quad[1];
      x_p[2]  <= x_p[1];
      x2_p[2] <= x2_p[1];
      sa2     <= ONE_Q30 - 31'(div_q(x2_p[1], DIV42));
      ca2     <= ONE_Q30 - 31'(div_q(x2_p[1], DIV56));
    end
    if (en[3]) begin
      quad[3] <= quad[2];
      x_p[3]  <= x_p[2];
      x2_p[3] <= x2_p[2];
      sb3     <= 30'(rnd30($signed(64'(x2_p[2])) * $signed(64'(sa2))));
      cb3     <= 30'(rnd30($signed(64'(x2_p[2])) * $signed(64'(ca2))));
    end
    if (en[4]) begin
      quad[4] <= quad[3];
      x_p[4]  <= x_p[3];
      x2_p[4] <= x2_p[3];
      sa4     <= ONE_Q30 - 31'(div_q(sb3, DIV20));
      ca4     <= ONE_Q30 - 31'(div_q(cb3, DIV30));
    end
    if (en[5]) begin
      quad[5] <= quad[4];
      x_p[5]  <= x_p[4];
      x2_p[5] <= x2_p[4];
      sb5     <= 30'(rnd30($signed(64'(x2_p[4])) * $signed(64'(sa4))));
      cb5     <= 30'(rnd30($signed(64'(x2_p[4])) * $signed(64'(ca4))));
    end
    if (en[6]) begin
      quad[6] <= quad[5];
      x_p[6]  <= x_p[5];
      x2_p[6] <= x2_p[5];
      sa6     <= ONE_Q30 - 31'(div_q(sb5, DIV6));
      ca6     <= ONE_Q30 - 31'(div_q(cb5, DIV12));
    end
    if (en[7]) begin
      quad[7] <= quad[6];
      ts7     <= 31'(rnd30(64'(x_p[6]) * $signed(64'(sa6))));
      cb7     <= 30'(rnd30($signed(64'(x2_p[6])) * $signed(64'(ca6))));
    end
    if (en[8]) begin
      case (quad[7])
        2'd0: begin
          sn <= ts_s;
          cs <= tc_s;
        end
        2'd1: begin
          sn <= tc_s;
          cs <= -ts_s;
        end
        2'd2: begin
          sn <= -ts_s;
          cs <= -tc_s;
        end
        default: begin
          sn <= -tc_s;
          cs <= ts_s;
        end
      endcase
    end
  end

  always_comb begin
    tc_c = ONE_Q30 - 31'(cb7[29:1]);
    tc_s = $signed({1'b0, tc_c});
    ts_s = SC_W'(ts7);
  end

endmodule

@@ rtl/scan_polar_to_cartesian_rigid_tf.sv @@
// Top level: lidar range sample to a point in the target frame, fully pipelined.
`timescale 1ns / 1ps

//  channel  direction  handshake               payload
//  beam     in         beam_valid/beam_stall   beam_index, range_m
//  point    out        point_valid/point_stall point_x, point_y
//  cfg      in         cfg_we (no handshake)   cfg_index, cfg_data
//
// One sample is taken per cycle while beam_stall is low; results come out of
// the 25-stage datapath (angle build, mod-2pi, nine stages of sine/cosine,
// three rotations) in order. Reset clears the stage valid bits and the
// configuration registers. A stage that is empty loads even while the output
// is stalled, so bubbles close up and a sample is taken while a result waits.

module scan_polar_to_cartesian_rigid_tf import sptc_pkg::*; #(
  parameter int MAX_BEAMS = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    beam_valid,
  output logic                    beam_stall,
  input  logic [IDX_W-1:0]        beam_index,
  input  logic [RNG_W-1:0]        range_m,
  output logic                    point_valid,
  input  logic                    point_stall,
  output logic signed [OUT_W-1:0] point_x,
  output logic signed [OUT_W-1:0] point_y,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  // Index reduction modulo MAX_BEAMS by an exact reciprocal multiply.
  localparam int MB_L     = $clog2(MAX_BEAMS);
  localparam int MB_SHIFT = IDX_W + MB_L;
  localparam int MG_W     = IDX_W + 2;
  localparam logic [MG_W-1:0] MB_MAGIC =
    MG_W'(((64'd1 << MB_SHIFT) + 64'(MAX_BEAMS) - 64'd1) / 64'(MAX_BEAMS));
  localparam int MB_W = $clog2(MAX_BEAMS + 1);
  localparam int QM_W = IDX_W + MB_W;

  localparam int N_ST   = 25;
  localparam int SC_LO  = 8;  // first stage inside the sine/cosine unit
  localparam int RNG_ST = SC_LO + SC_STAGES;  // stage that consumes the range

  // Configuration. Angles are kept already reduced to [0, 2pi).
  logic [RED_W-1:0]        start_r, step_r, src_h_r, tgt_h_r;
  logic signed [REG_W-1:0] src_x, src_y, tgt_x, tgt_y;
  logic signed [REG_W:0]   trans_x, trans_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_r <= '0;
      step_r  <= '0;
      src_h_r <= '0;
      tgt_h_r <= '0;
      src_x   <= '0;
      src_y   <= '0;
      tgt_x   <= '0;
      tgt_y   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_ANGLE: start_r <= reduce_ang($signed(cfg_data));
        REG_ANGLE_STEP:  step_r  <= reduce_ang($signed(cfg_data));
        REG_SRC_X:       src_x   <= $signed(cfg_data);
        REG_SRC_Y:       src_y   <= $signed(cfg_data);
        REG_SRC_HEADING: src_h_r <= reduce_ang($signed(cfg_data));
        REG_TGT_X:       tgt_x   <= $signed(cfg_data);
        REG_TGT_Y:       tgt_y   <= $signed(cfg_data);
        REG_TGT_HEADING: tgt_h_r <= reduce_ang($signed(cfg_data));
      endcase
    end
  end

  // The two translations fold into one offset added after the source rotation.
  // The user must change registers only while the pipe is empty (the block
  // does not enforce it), so this settles long before any sample reaches the add.
  always_ff @(posedge clk) begin
    trans_x <= (REG_W+1)'(src_x) - (REG_W+1)'(tgt_x);
    trans_y <= (REG_W+1)'(src_y) - (REG_W+1)'(tgt_y);
  end

  // Stage control. A stage loads when it is empty or when the whole pipe
  // advances; a full stage whose content moved on without a refill goes
  // empty, so nothing is lost or repeated.
  logic [N_ST-1:0] vld;
  logic [N_ST-1:0] en;
  logic            adv;

  always_comb begin
    adv = !vld[N_ST-1] || !point_stall;
    for (int k = 0; k < N_ST; k++) begin
      en[k] = !vld[k] || adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= beam_valid;
      end else if (en[1]) begin
        vld[0] <= 1'b0;
      end
      for (int k = 1; k < N_ST - 1; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end else if (en[k+1]) begin
          vld[k] <= 1'b0;
        end
      end
      if (en[N_ST-1]) begin
        vld[N_ST-1] <= vld[N_ST-2];
      end
    end
  end

  assign beam_stall  = !en[0];
  assign point_valid = vld[N_ST-1];

  // The range rides along until the beam sine and cosine are ready.
  logic [RNG_W-1:0] rng_p [0:RNG_ST-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rng_p[0] <= range_m;
    end
    for (int k = 1; k < RNG_ST; k++) begin
      if (en[k]) begin
        rng_p[k] <= rng_p[k-1];
      end
    end
  end

  // Beam angle: index mod MAX_BEAMS, times step, plus start, then mod 2pi.
  logic [IDX_W-1:0]      idx0, idx1, qi1, idx2;
  logic [IDX_W+MG_W-1:0] mb_prod;
  logic [QM_W-1:0]       qm;
  logic [34:0]           prod3, s4, s5;
  logic [48:0]           ap;
  logic [12:0]           qe5;
  logic [23:0]           r6;
  logic [RED_W-1:0]      r7;

  always_comb begin
    mb_prod = (IDX_W+MG_W)'(idx0) * (IDX_W+MG_W)'(MB_MAGIC);
    qm      = QM_W'(qi1) * QM_W'(MAX_BEAMS);
    ap      = 49'(s4) * 49'(ANG_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx0 <= beam_index;
    end
    if (en[1]) begin
      idx1 <= idx0;
      qi1  <= IDX_W'(mb_prod >> MB_SHIFT);
    end
    if (en[2]) begin
      idx2 <= idx1 - qm[IDX_W-1:0];
    end
    if (en[3]) begin
      prod3 <= 35'(idx2) * 35'(step_r);
    end
    if (en[4]) begin
      s4 <= prod3 + 35'(start_r);
    end
    if (en[5]) begin
      s5  <= s4;
      qe5 <= 13'(ap >> 36);
    end
    if (en[6]) begin
      r6 <= 24'(36'(s5) - 36'(qe5) * 36'(TWO_PI));
    end
    if (en[7]) begin
      r7 <= (r6 >= 24'(TWO_PI)) ? RED_W'(r6 - 24'(TWO_PI)) : r6[RED_W-1:0];
    end
  end

  // Sine and cosine of the beam angle follow the sample; the two heading
  // units run freely on their constant registers.
  logic signed [SC_W-1:0] b_sn, b_cs, s_sn, s_cs, t_sn, t_cs;

  sptc_sincos u_beam_sc (
    .clk (clk),
    .en  (en[SC_LO +: SC_STAGES]),
    .ang (r7),
    .sn  (b_sn),
    .cs  (b_cs)
  );

  sptc_sincos u_src_sc (
    .clk (clk),
    .en  ({SC_STAGES{1'b1}}),
    .ang (src_h_r),
    .sn  (s_sn),
    .cs  (s_cs)
  );

  sptc_sincos u_tgt_sc (
    .clk (clk),
    .en  ({SC_STAGES{1'b1}}),
    .ang (tgt_h_r),
    .sn  (t_sn),
    .cs  (t_cs)
  );

  // Polar to Cartesian, source pose, then inverse target pose.
  logic signed [56:0] pxp, pyp;
  logic signed [25:0] px, py;
  logic signed [57:0] mxa, mxb, mya, myb;
  logic signed [58:0] ux, uy;
  logic signed [27:0] dx, dy;
  logic signed [59:0] na, nb, nc, nd;
  logic signed [60:0] vx, vy;
  logic signed [63:0] rng_s;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    if (v > 64'sd16777215) begin
      return $signed(25'h0FF_FFFF);
    end else if (v < -64'sd16777216) begin
      return $signed(25'h100_0000);
    end
    return v[OUT_W-1:0];
  endfunction

  assign rng_s = $signed(64'(rng_p[RNG_ST-1]));

  always_ff @(posedge clk) begin
    if (en[17]) begin
      pxp <= 57'(rng_s * 64'(b_cs));
      pyp <= 57'(rng_s * 64'(b_sn));
    end
    if (en[18]) begin
      px <= 26'(rnd30(64'(pxp)));
      py <= 26'(rnd30(64'(pyp)));
    end
    if (en[19]) begin
      mxa <= 58'(64'(s_cs) * 64'(px));
      mxb <= 58'(64'(s_sn) * 64'(py));
      mya <= 58'(64'(s_sn) * 64'(px));
      myb <= 58'(64'(s_cs) * 64'(py));
    end
    if (en[20]) begin
      ux <= 59'(mxa) - 59'(mxb);
      uy <= 59'(mya) + 59'(myb);
    end
    if (en[21]) begin
      dx <= 28'(rnd30(64'(ux))) + 28'(trans_x);
      dy <= 28'(rnd30(64'(uy))) + 28'(trans_y);
    end
    if (en[22]) begin
      na <= 60'(64'(t_cs) * 64'(dx));
      nb <= 60'(64'(t_sn) * 64'(dy));
      nc <= 60'(64'(t_cs) * 64'(dy));
      nd <= 60'(64'(t_sn) * 64'(dx));
    end
    if (en[23]) begin
      vx <= 61'(na) + 61'(nb);
      vy <= 61'(nc) - 61'(nd);
    end
    if (en[24]) begin
      point_x <= sat_out(rnd30(64'(vx)));
      point_y <= sat_out(rnd30(64'(vy)));
    end
  end

endmodule
